FILE: design/sm64_pkg.sv
// Shared types and constants for the splitmix64 bounded random unit.
package sm64_pkg;

	localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
	localparam int unsigned SHIFT_1     = 30;
	localparam int unsigned SHIFT_2     = 27;
	localparam int unsigned SHIFT_3     = 31;
	localparam int unsigned HALF_W      = 32;

	localparam int unsigned DIV_STEPS   = 64;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [2:0] OP_RAW64   = 3'd0;
	localparam logic [2:0] OP_UPPER32 = 3'd1;
	localparam logic [2:0] OP_BOUNDED = 3'd2;
	localparam logic [2:0] OP_RANGE   = 3'd3;
	localparam logic [2:0] OP_CHANCE  = 3'd4;

	localparam logic REG_SEED = 1'b0;

	typedef enum logic [2:0] {
		KIND_CONST,
		KIND_RAW,
		KIND_UPPER,
		KIND_MOD,
		KIND_CHANCE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] divisor;
		logic [63:0] operand;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} back_state_t;

endpackage

FILE: design/sm64_front.sv
// Request front end: classifies each item into a work entry for the queue.
module sm64_front (
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         operation,
	input  logic [63:0]        bound,
	input  logic [63:0]        numerator,
	input  logic signed [63:0] range_low,
	input  logic signed [63:0] range_high,
	input  logic               q_full,
	output logic               q_push,
	output sm64_pkg::entry_t   q_entry
);
	import sm64_pkg::*;

	logic [63:0] span_w;
	logic        range_empty;

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	assign span_w      = $unsigned(range_high) - $unsigned(range_low) + 64'd1;
	assign range_empty = (range_high <= range_low) || (span_w == 64'd0);

	always_comb begin
		q_entry.kind    = KIND_CONST;
		q_entry.divisor = bound;
		q_entry.operand = 64'd0;
		case (operation)
			OP_RAW64: begin
				q_entry.kind = KIND_RAW;
			end
			OP_UPPER32: begin
				q_entry.kind = KIND_UPPER;
			end
			OP_BOUNDED: begin
				if (bound != 64'd0) begin
					q_entry.kind = KIND_MOD;
				end
			end
			OP_RANGE: begin
				q_entry.operand = $unsigned(range_low);
				q_entry.divisor = span_w;
				if (!range_empty) begin
					q_entry.kind = KIND_MOD;
				end
			end
			OP_CHANCE: begin
				if (bound != 64'd0) begin
					q_entry.kind    = KIND_CHANCE;
					q_entry.operand = numerator;
				end
			end
			default: begin
				q_entry.kind = KIND_CONST;
			end
		endcase
	end

endmodule

FILE: design/sm64_queue.sv
// Short queue of work entries between the front end and the generator.
module sm64_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sm64_pkg::entry_t push_entry,
	input  logic             pop,
	output sm64_pkg::entry_t head,
	output logic             full,
	output logic             empty
);
	import sm64_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	entry_t            slot_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count above depth");
`endif

endmodule

FILE: design/sm64_back.sv
// Generator back end: counter, sliced splitmix multiply, remainder divider, result register.
module sm64_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             q_pop,
	input  sm64_pkg::entry_t q_head,
	input  logic             seed_load,
	input  logic [63:0]      seed_value,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [63:0]      value,
	output logic             hit
);
	import sm64_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	entry_t               entry_q;
	logic [63:0]          counter_q;
	logic [63:0]          x_q;
	logic [63:0]          acc_q;
	logic [63:0]          prod_q;
	logic [1:0]           mstep_q;
	logic                 pass_q;
	logic [63:0]          rem_q;
	logic [63:0]          dividend_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [63:0]          value_q;
	logic                 hit_q;

	logic [63:0]          counter_next;
	logic [63:0]          mul_const;
	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          mul_p;
	logic [63:0]          mul_fin;
	logic [63:0]          mixed;
	logic                 mix_last;
	logic [64:0]          trial;
	logic [64:0]          diff;
	logic                 div_last;

	assign counter_next = counter_q + GOLDEN_STEP;
	assign mul_const    = pass_q ? MIX_MUL_B : MIX_MUL_A;

	always_comb begin
		case (mstep_q)
			2'd1: begin
				mul_a = x_q[63:32];
				mul_b = mul_const[31:0];
			end
			2'd2: begin
				mul_a = x_q[31:0];
				mul_b = mul_const[63:32];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = mul_const[31:0];
			end
		endcase
	end

	assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
	assign mul_fin  = acc_q + {prod_q[HALF_W-1:0], 32'd0};
	assign mixed    = mul_fin ^ (mul_fin >> SHIFT_3);
	assign mix_last = (mstep_q == 2'd3) && pass_q;

	assign trial    = {rem_q, dividend_q[63]};
	assign diff     = trial - {1'b0, entry_q.divisor};
	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_head.kind == KIND_CONST) ? ST_OUT : ST_MIX;
				end
			end
			ST_MIX: begin
				if (mix_last) begin
					if (entry_q.kind == KIND_RAW || entry_q.kind == KIND_UPPER) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= 64'd0;
			mstep_q   <= 2'd0;
			pass_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (seed_load) begin
				counter_q <= seed_value;
			end else if (state_q == ST_IDLE && !q_empty && q_head.kind != KIND_CONST) begin
				counter_q <= counter_next;
			end
			case (state_q)
				ST_IDLE: begin
					mstep_q   <= 2'd0;
					pass_q    <= 1'b0;
					div_cnt_q <= '0;
				end
				ST_MIX: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd3) begin
						pass_q <= 1'b1;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				default: begin
					div_cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				entry_q <= q_head;
				x_q     <= counter_next ^ (counter_next >> SHIFT_1);
				value_q <= q_head.operand;
				hit_q   <= 1'b0;
			end
			ST_MIX: begin
				prod_q <= mul_p;
				case (mstep_q)
					2'd1: acc_q <= prod_q;
					2'd2: acc_q <= mul_fin;
					default: acc_q <= acc_q;
				endcase
				if (mstep_q == 2'd3 && !pass_q) begin
					x_q <= mul_fin ^ (mul_fin >> SHIFT_2);
				end
				if (mix_last) begin
					value_q    <= (entry_q.kind == KIND_UPPER) ? (mixed >> HALF_W) : mixed;
					dividend_q <= mixed;
					rem_q      <= 64'd0;
				end
			end
			ST_DIV: begin
				dividend_q <= dividend_q << 1;
				rem_q      <= diff[64] ? trial[63:0] : diff[63:0];
			end
			ST_FIN: begin
				if (entry_q.kind == KIND_CHANCE) begin
					value_q <= 64'd0;
					hit_q   <= (rem_q < entry_q.operand);
				end else begin
					value_q <= entry_q.operand + rem_q;
					hit_q   <= 1'b0;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign rsp_valid = (state_q == ST_OUT);
	assign value     = value_q;
	assign hit       = hit_q;

`ifndef SYNTHESIS
	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !seed_load) |=> $stable(counter_q))
		else $error("counter moved while result waits");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (rem_q < entry_q.divisor))
		else $error("remainder not below divisor");
	a_no_mix_for_const: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) |-> (entry_q.kind != KIND_CONST))
		else $error("draw started for constant item");
`endif

endmodule

FILE: design/splitmix64_bounded_random_unit.sv
// Top level of the splitmix64 bounded random unit: seed register, front end, queue, generator.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  request  | req_valid/req_stall| operation, bound, numerator, range_low, range_high
//  response | rsp_valid/rsp_stall| value, hit
//  config   | APB, pready tied 1 | seed at byte address 0 (64-bit data)
//
// Per item, from queue head to result: items with no draw go straight to the result register;
// raw64 and upper32 pass through the sliced 32x32 multiplies of the mix; bounded, range and chance
// then also pass through the 64-step restoring remainder divider.
// Reset clears counter, seed, queue and state; no clearing pass.
// The queue keeps taking items while a result waits on rsp_stall, until it is full.
module splitmix64_bounded_random_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         operation,
	input  logic [63:0]        bound,
	input  logic [63:0]        numerator,
	input  logic signed [63:0] range_low,
	input  logic signed [63:0] range_high,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [63:0]        value,
	output logic               hit,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import sm64_pkg::*;

	logic [63:0] seed_q;
	logic        seed_load;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	entry_t      q_entry;
	entry_t      q_head;

	assign pready    = 1'b1;
	assign seed_load = psel && penable && pwrite && (paddr[3] == REG_SEED);
	assign prdata    = (paddr[3] == REG_SEED) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (seed_load) begin
			seed_q <= pwdata;
		end
	end

	sm64_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.bound      (bound),
		.numerator  (numerator),
		.range_low  (range_low),
		.range_high (range_high),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	sm64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	sm64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_head     (q_head),
		.seed_load  (seed_load),
		.seed_value (pwdata),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.value      (value),
		.hit        (hit)
	);

endmodule
